[src/arsc_pkg.sv]
package arsc_pkg;

    // default parameter values
    localparam int SAMPLE_WIDTH_DEF = 13;
    localparam int HOLD_SAMPLES_DEF = 3;
    localparam int MIN_GAP_DEF      = 12;
    localparam int CALM_SECONDS_DEF = 4;

    // field widths
    localparam int CMD_W   = 3;
    localparam int W16     = 16;
    localparam int USER_W  = 4;
    localparam int SENS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_TARGET = 1'b1;

    localparam logic [SENS_W-1:0] SENS_COARSE = 2'd1;
    localparam logic [SENS_W-1:0] SENS_FINE   = 2'd3;
    localparam logic [SENS_W-1:0] SENS_RESET  = 2'd2;
    localparam logic [W16-1:0]    TARGET_RESET = 16'd90;

    localparam int THR_COARSE   = 260;
    localparam int THR_MEDIUM   = 180;
    localparam int THR_FINE     = 110;
    localparam int CALM_LIMIT   = 55;
    localparam int ACTIVE_LIMIT = 130;

    // result word layout
    localparam int O_SETS     = 16;
    localparam int O_RESTING  = 32;
    localparam int O_REST_SEC = 33;
    localparam int O_BUZZ     = 49;
    localparam int O_DONE     = 50;
    localparam int O_SSTART   = 51;
    localparam int OUT_BITS   = 99;
    localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_BASE,
        ST_TRIG,
        ST_RESULT
    } t_state;

endpackage

[src/accel_rep_and_set_counter.sv]
// sample item: after accept, the three squares are summed on one multiplier, the
// square root runs SAMPLE_WIDTH+1 steps on one subtract-compare unit, then the
// filter, trigger and result load states follow; the result load waits while the
// output slot is full. Other items go straight to the result load. No new item is
// accepted until the result is loaded. Synchronous active-low reset clears run state
// (gap count to MIN_GAP), sensitivity to 2, rest target to 90
module accel_rep_and_set_counter #(
    parameter int SAMPLE_WIDTH = arsc_pkg::SAMPLE_WIDTH_DEF,
    parameter int HOLD_SAMPLES = arsc_pkg::HOLD_SAMPLES_DEF,
    parameter int MIN_GAP      = arsc_pkg::MIN_GAP_DEF,
    parameter int CALM_SECONDS = arsc_pkg::CALM_SECONDS_DEF,
    localparam int IN_DW = ((3 * SAMPLE_WIDTH + arsc_pkg::W16 + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // accel_x, accel_y, accel_z, second
    input  logic [IN_DW-1:0]                  s_axis_tdata,
    // cmd, vibrating
    input  logic [arsc_pkg::USER_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // reps_running, sets_done, resting, rest_seconds, buzz, set_done,
    // set_start, set_reps, set_duration
    output logic [arsc_pkg::OUT_DW-1:0]       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [arsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [arsc_pkg::W16-1:0]          i_cfg_data
);
    import arsc_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int MAG_W  = SW + 1;
    localparam int DW     = SW + 2;
    localparam int ACC_W  = 2 * MAG_W;
    localparam int RW     = MAG_W + 3;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int HOLD_W = $clog2(HOLD_SAMPLES + 1);
    localparam int CALM_W = $clog2(CALM_SECONDS + 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // config
    logic [SENS_W-1:0] r_sens;
    logic [W16-1:0]    r_target;

    // run state
    logic              r_enabled, n_enabled, r_paused, n_paused;
    logic [MAG_W-1:0]  r_base, n_base, r_motion, n_motion;
    logic              r_above, n_above;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [W16-1:0]    r_since, n_since, r_reps, n_reps, r_sets, n_sets;
    logic [W16-1:0]    r_set_begin, n_set_begin;
    logic [CALM_W-1:0] r_calm, n_calm;
    logic              r_in_rest, n_in_rest, r_buzzed, n_buzzed;
    logic [W16-1:0]    r_rest_begin, n_rest_begin, r_rest_len, n_rest_len;

    // per-item working registers
    logic [SW-1:0]     r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [RW-1:0]     r_rem, n_rem;
    logic [MAG_W-1:0]  r_root, n_root;
    logic              r_buzz, n_buzz, r_done, n_done;
    logic [W16-1:0]    r_sstart, n_sstart, r_sreps, n_sreps, r_sdur, n_sdur;

    logic                r_ovalid, n_ovalid;
    logic [OUT_DW-1:0]   r_odata, n_odata;

    // combinational helpers
    logic [CMD_W-1:0]  in_cmd;
    logic              in_vib;
    logic [W16-1:0]    in_sec;
    logic              accept;
    logic [SW-1:0]     sq_op, sq_abs;
    logic [2*SW-1:0]   sq_prod;
    logic [RW-1:0]     rem_sh, trial;
    logic [MAG_W-1:0]  base0;
    logic signed [DW-1:0] diff, step, dev, adev_s, thr, mdiff, mstep;
    logic [MAG_W-1:0]  adev;
    logic [W16-1:0]    since1, sec_end;
    logic [HOLD_W-1:0] hold1;
    logic [CALM_W-1:0] calm1;
    logic              rest1, buzzed1;
    logic [W16-1:0]    reps1, rest_begin1;
    logic [W16:0]      buzz_at;

    assign in_cmd = s_axis_tuser[CMD_W-1:0];
    assign in_vib = s_axis_tuser[CMD_W];
    assign in_sec = s_axis_tdata[3*SW +: W16];
    assign accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        case (r_sens)
            SENS_COARSE: thr = DW'(THR_COARSE);
            SENS_FINE:   thr = DW'(THR_FINE);
            default:     thr = DW'(THR_MEDIUM);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens   <= SENS_RESET;
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SENSITIVITY) r_sens <= i_cfg_data[SENS_W-1:0];
            if (i_cfg_idx == REG_REST_TARGET) r_target <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_enabled    <= 1'b0;
            r_paused     <= 1'b0;
            r_base       <= '0;
            r_motion     <= '0;
            r_above      <= 1'b0;
            r_hold       <= '0;
            r_since      <= W16'(MIN_GAP);
            r_reps       <= '0;
            r_sets       <= '0;
            r_set_begin  <= '0;
            r_calm       <= '0;
            r_in_rest    <= 1'b0;
            r_rest_begin <= '0;
            r_rest_len   <= '0;
            r_buzzed     <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_enabled    <= n_enabled;
            r_paused     <= n_paused;
            r_base       <= n_base;
            r_motion     <= n_motion;
            r_above      <= n_above;
            r_hold       <= n_hold;
            r_since      <= n_since;
            r_reps       <= n_reps;
            r_sets       <= n_sets;
            r_set_begin  <= n_set_begin;
            r_calm       <= n_calm;
            r_in_rest    <= n_in_rest;
            r_rest_begin <= n_rest_begin;
            r_rest_len   <= n_rest_len;
            r_buzzed     <= n_buzzed;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_az     <= n_az;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_buzz   <= n_buzz;
        r_done   <= n_done;
        r_sstart <= n_sstart;
        r_sreps  <= n_sreps;
        r_sdur   <= n_sdur;
        r_odata  <= n_odata;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_enabled    = r_enabled;
        n_paused     = r_paused;
        n_base       = r_base;
        n_motion     = r_motion;
        n_above      = r_above;
        n_hold       = r_hold;
        n_since      = r_since;
        n_reps       = r_reps;
        n_sets       = r_sets;
        n_set_begin  = r_set_begin;
        n_calm       = r_calm;
        n_in_rest    = r_in_rest;
        n_rest_begin = r_rest_begin;
        n_rest_len   = r_rest_len;
        n_buzzed     = r_buzzed;
        n_ax         = r_ax;
        n_ay         = r_ay;
        n_az         = r_az;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_root       = r_root;
        n_buzz       = r_buzz;
        n_done       = r_done;
        n_sstart     = r_sstart;
        n_sreps      = r_sreps;
        n_sdur       = r_sdur;
        n_ovalid     = r_ovalid;
        n_odata      = r_odata;

        // shared multiplier: one square per cycle
        case (r_cnt[1:0])
            2'd0:    sq_op = r_ax;
            2'd1:    sq_op = r_ay;
            default: sq_op = r_az;
        endcase
        sq_abs  = sq_op[SW-1] ? SW'(-sq_op) : sq_op;
        sq_prod = {{SW{1'b0}}, sq_abs} * {{SW{1'b0}}, sq_abs};

        // shared root step: two radicand bits per cycle
        rem_sh = {r_rem[RW-3:0], r_acc[ACC_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};

        // baseline and motion filters, division truncates toward zero
        base0  = (r_base == '0) ? r_root : r_base;
        diff   = $signed({1'b0, r_root}) - $signed({1'b0, base0});
        step   = (diff + (diff[DW-1] ? DW'(15) : DW'(0))) >>> 4;
        dev    = $signed({1'b0, r_root}) - $signed({1'b0, r_base});
        adev_s = dev[DW-1] ? -dev : dev;
        adev   = adev_s[MAG_W-1:0];
        mdiff  = $signed({1'b0, adev}) - $signed({1'b0, r_motion});
        mstep  = (mdiff + (mdiff[DW-1] ? DW'(7) : DW'(0))) >>> 3;

        since1 = (r_since == 16'hFFFF) ? r_since : r_since + 16'd1;
        if (dev > thr) begin
            hold1 = (r_hold < HOLD_W'(HOLD_SAMPLES)) ? r_hold + HOLD_W'(1) : r_hold;
        end else begin
            hold1 = '0;
        end

        // tick path
        if (r_motion < MAG_W'(CALM_LIMIT)) begin
            calm1 = (r_calm < CALM_W'(CALM_SECONDS)) ? r_calm + CALM_W'(1) : r_calm;
        end else if (r_motion > MAG_W'(ACTIVE_LIMIT)) begin
            calm1 = '0;
        end else begin
            calm1 = r_calm;
        end
        sec_end = (in_sec > W16'(CALM_SECONDS)) ? in_sec - W16'(CALM_SECONDS) : in_sec;
        rest1       = r_in_rest;
        rest_begin1 = r_rest_begin;
        buzzed1     = r_buzzed;
        reps1       = r_reps;
        if (!r_in_rest && calm1 >= CALM_W'(CALM_SECONDS)) begin
            rest1       = 1'b1;
            rest_begin1 = in_sec;
            buzzed1     = 1'b0;
            reps1       = '0;
        end
        buzz_at = {1'b0, rest_begin1} + {1'b0, r_target};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_buzz   = 1'b0;
                    n_done   = 1'b0;
                    n_sstart = '0;
                    n_sreps  = '0;
                    n_sdur   = '0;
                    n_state  = ST_RESULT;
                    case (in_cmd)
                        CMD_SAMPLE: begin
                            if (r_enabled && !r_paused && !in_vib) begin
                                n_ax    = s_axis_tdata[0 +: SW];
                                n_ay    = s_axis_tdata[SW +: SW];
                                n_az    = s_axis_tdata[2*SW +: SW];
                                n_acc   = '0;
                                n_cnt   = '0;
                                n_state = ST_SQUARE;
                            end
                        end
                        CMD_TICK: begin
                            if (r_enabled && !r_paused) begin
                                n_calm = calm1;
                                if (!r_in_rest && calm1 >= CALM_W'(CALM_SECONDS) &&
                                    r_reps >= 16'd2) begin
                                    n_done   = 1'b1;
                                    n_sstart = r_set_begin;
                                    n_sreps  = r_reps;
                                    n_sdur   = (sec_end > r_set_begin) ?
                                               sec_end - r_set_begin : '0;
                                    n_sets   = r_sets + 16'd1;
                                end
                                n_in_rest    = rest1;
                                n_rest_begin = rest_begin1;
                                n_reps       = reps1;
                                n_rest_len   = (rest1 && in_sec > rest_begin1) ?
                                               in_sec - rest_begin1 : '0;
                                n_buzzed     = buzzed1;
                                if (rest1 && !buzzed1 && r_target != '0 &&
                                    {1'b0, in_sec} >= buzz_at) begin
                                    n_buzz   = 1'b1;
                                    n_buzzed = 1'b1;
                                end
                                if (!rest1 && reps1 == 16'd1) n_set_begin = in_sec;
                            end
                        end
                        CMD_START: begin
                            n_enabled    = 1'b1;
                            n_paused     = 1'b0;
                            n_base       = '0;
                            n_motion     = '0;
                            n_above      = 1'b0;
                            n_hold       = '0;
                            n_since      = W16'(MIN_GAP);
                            n_reps       = '0;
                            n_sets       = '0;
                            n_set_begin  = '0;
                            n_calm       = '0;
                            n_in_rest    = 1'b0;
                            n_rest_begin = '0;
                            n_rest_len   = '0;
                            n_buzzed     = 1'b0;
                        end
                        CMD_STOP: begin
                            if (r_enabled) begin
                                if (!r_in_rest && r_reps >= 16'd2) begin
                                    n_done   = 1'b1;
                                    n_sstart = r_set_begin;
                                    n_sreps  = r_reps;
                                    n_sdur   = (in_sec > r_set_begin) ?
                                               in_sec - r_set_begin : '0;
                                    n_sets   = r_sets + 16'd1;
                                    n_reps   = '0;
                                end
                                n_enabled = 1'b0;
                            end
                        end
                        CMD_PAUSE:  n_paused = 1'b1;
                        CMD_RESUME: n_paused = 1'b0;
                        default: ;
                    endcase
                end
            end
            ST_SQUARE: begin
                n_acc = r_acc + ACC_W'(sq_prod);
                if (r_cnt == CNT_W'(2)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_ROOT: begin
                n_acc = {r_acc[ACC_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {r_root[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {r_root[MAG_W-2:0], 1'b0};
                end
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_BASE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_BASE: begin
                // r_root now holds the magnitude
                n_base  = base0 + step[MAG_W-1:0];
                n_state = ST_TRIG;
            end
            ST_TRIG: begin
                n_motion = r_motion + mstep[MAG_W-1:0];
                n_since  = since1;
                n_hold   = hold1;
                if (!r_above && hold1 >= HOLD_W'(HOLD_SAMPLES)) begin
                    n_above = 1'b1;
                    if (since1 >= W16'(MIN_GAP)) begin
                        n_reps  = r_reps + 16'd1;
                        n_since = '0;
                        if (r_in_rest) begin
                            n_in_rest = 1'b0;
                            n_buzzed  = 1'b0;
                        end
                    end
                end else if (r_above && dev < -thr) begin
                    n_above = 1'b0;
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = OUT_DW'({r_sdur, r_sreps, r_sstart, r_done, r_buzz,
                                        r_rest_len, r_in_rest, r_sets, r_reps});
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // output slot drains independently unless refilled above
        if (r_ovalid && m_axis_tready && !(r_state == ST_RESULT)) n_ovalid = 1'b0;
    end

`ifndef ASSERT_OFF
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_cmd == CMD_SAMPLE && r_enabled && !r_paused && !in_vib)
        |=> (r_state == ST_SQUARE))
        else $error("active sample did not start the square phase");

    a_buzz_in_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[O_BUZZ]) |-> m_axis_tdata[O_RESTING])
        else $error("buzz raised outside a rest period");

    a_set_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[O_DONE])
        |-> (m_axis_tdata[OUT_BITS-1:O_SSTART] == '0))
        else $error("set data present without a closed set");

    a_counters_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold <= HOLD_W'(HOLD_SAMPLES)) && (r_calm <= CALM_W'(CALM_SECONDS)))
        else $error("hold or calm count beyond its limit");

    a_root_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> (r_cnt <= CNT_W'(MAG_W - 1)))
        else $error("root step count out of range");
`endif

endmodule
